/* hdl/sowc_pkg.sv */
// sowc_pkg: types and constants shared by the spike onset window counter.
// Holds the channel payload structs, the register map and the back-end states.
// No dependencies.
package sowc_pkg;

	localparam int SUM_W  = 26;
	localparam int CNT_W  = 9;
	localparam int STEP_W = 32;
	localparam int LFP_W  = 17;
	localparam int NUM_W  = SUM_W + 1;   // sum plus rest offset
	localparam int DIV_W  = 9;

	// sum saturation limits, on the widened sum
	localparam logic signed [SUM_W:0] SUM_MAX = 27'sd33554431;
	localparam logic signed [SUM_W:0] SUM_MIN = -27'sd33554432;
	// resting offset of -70 mV in Q8.8
	localparam logic signed [NUM_W-1:0] REST_Q88 = -27'sd17920;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	// field potential limits, on the signed quotient
	localparam logic signed [NUM_W:0] LFP_MAX = 28'sd65535;
	localparam logic signed [NUM_W:0] LFP_MIN = -28'sd65536;

	typedef enum logic [1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_NUM_INPUTS = 2'd1,
		REG_WINDOW     = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic [7:0]         channel;
		logic signed [15:0] voltage;
		logic               step_last;
	} sample_t;

	typedef struct packed {
		logic signed [LFP_W-1:0] lfp;
		logic [CNT_W-1:0]        spike_count;
	} result_t;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic [8:0]         num_inputs;
		logic [15:0]        window_steps;
	} cfg_t;

	// per-step totals handed from the front end to the divider
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} step_tot_t;

	typedef struct packed {
		logic      push;
		step_tot_t tot;
	} q_wr_t;

	typedef struct packed {
		logic      valid;
		step_tot_t tot;
	} q_rd_t;

endpackage

/* hdl/sowc_front.sv */
// sowc_front: per-channel onset tracking, window test and per-step accumulation.
// Uses sowc_pkg. Holds the onset and above-threshold memories and the never-fired bits.
module sowc_front #(
	parameter int MAX_CHANNELS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sowc_pkg::cfg_t     cfg,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  sowc_pkg::sample_t  sample,
	output sowc_pkg::q_wr_t    q_wr,
	input  logic               q_full
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic                                 s1_valid_q;
	sowc_pkg::sample_t                    item_s1;
	logic [sowc_pkg::STEP_W-1:0]          onset_rd_s1;
	logic                                 above_rd_s1;
	logic [sowc_pkg::STEP_W-1:0]          onset_mem [MAX_CHANNELS];
	logic                                 above_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]              never_q;
	logic [sowc_pkg::STEP_W-1:0]          step_q;
	logic signed [sowc_pkg::SUM_W-1:0]    sum_q;
	logic [sowc_pkg::CNT_W-1:0]           cnt_q;

	logic                                 accept;
	logic                                 advance;
	logic [31:0]                          ch_in_ext;
	logic [31:0]                          ch_s1_ext;
	logic [IDX_W-1:0]                     idx_in;
	logic [IDX_W-1:0]                     idx_s1;
	logic                                 ch_ok;
	logic                                 hot;
	logic                                 above_now;
	logic                                 fire;
	logic                                 never_now;
	logic                                 in_win;
	logic [sowc_pkg::STEP_W-1:0]          age;
	logic signed [sowc_pkg::SUM_W:0]      sum_wide;
	logic signed [sowc_pkg::SUM_W-1:0]    sum_nxt;
	logic [sowc_pkg::CNT_W-1:0]           cnt_nxt;
	logic                                 wr_hit;
	logic                                 above_hit;

	assign ch_in_ext = 32'(sample.channel);
	assign ch_s1_ext = 32'(item_s1.channel);
	assign idx_in    = ch_in_ext[IDX_W-1:0];
	assign idx_s1    = ch_s1_ext[IDX_W-1:0];

	assign advance      = s1_valid_q && (!item_s1.step_last || !q_full);
	assign sample_ready = !s1_valid_q || advance;
	assign accept       = sample_valid && sample_ready;

	always_comb begin
		ch_ok     = ch_s1_ext < 32'(MAX_CHANNELS);
		hot       = item_s1.voltage > cfg.threshold;
		// a never-fired channel has never been above threshold
		above_now = !never_q[idx_s1] && above_rd_s1;
		fire      = ch_ok && hot && !above_now;
		never_now = never_q[idx_s1] && !fire;
		age       = step_q - onset_rd_s1;
		// a fresh onset sits at distance zero, always inside the window
		if (!ch_ok) begin
			in_win = 1'b0;
		end else if (fire) begin
			in_win = 1'b1;
		end else if (never_now) begin
			in_win = (step_q == '0);
		end else begin
			in_win = age <= 32'(cfg.window_steps);
		end
		sum_wide = (sowc_pkg::SUM_W + 1)'(sum_q) + (sowc_pkg::SUM_W + 1)'(item_s1.voltage);
		if (sum_wide > sowc_pkg::SUM_MAX) begin
			sum_nxt = sowc_pkg::SUM_MAX[sowc_pkg::SUM_W-1:0];
		end else if (sum_wide < sowc_pkg::SUM_MIN) begin
			sum_nxt = sowc_pkg::SUM_MIN[sowc_pkg::SUM_W-1:0];
		end else begin
			sum_nxt = sum_wide[sowc_pkg::SUM_W-1:0];
		end
		cnt_nxt = (in_win && cnt_q != sowc_pkg::CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		q_wr.push      = advance && item_s1.step_last;
		q_wr.tot.sum   = sum_nxt;
		q_wr.tot.count = cnt_nxt;
	end

	// read-before-write memories: forward what the item leaving s1 writes
	assign wr_hit    = advance && fire && (idx_s1 == idx_in);
	assign above_hit = advance && ch_ok && (idx_s1 == idx_in);

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			onset_mem[idx_s1] <= step_q;
		end
		if (advance && ch_ok) begin
			above_mem[idx_s1] <= hot;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= sample;
			onset_rd_s1 <= wr_hit ? step_q : onset_mem[idx_in];
			above_rd_s1 <= above_hit ? hot : above_mem[idx_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			never_q    <= '1;
			step_q     <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				if (ch_ok && fire) begin
					never_q[idx_s1] <= 1'b0;
				end
				if (item_s1.step_last) begin
					sum_q  <= '0;
					cnt_q  <= '0;
					step_q <= step_q + 1'b1;
				end else begin
					sum_q <= sum_nxt;
					cnt_q <= cnt_nxt;
				end
			end
		end
	end

	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.step_last |=> step_q == $past(step_q) + 1'b1)
		else $error("step counter did not advance on a closed step");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> s1_valid_q && item_s1.step_last && q_full)
		else $error("front stalled without a full queue");

endmodule

/* hdl/sowc_queue.sv */
// sowc_queue: two-entry queue of per-step totals between front end and divider.
// Uses sowc_pkg.
module sowc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  sowc_pkg::q_wr_t q_wr,
	output logic            q_full,
	output sowc_pkg::q_rd_t q_rd,
	input  logic            pop
);

	sowc_pkg::step_tot_t slot_q [2];
	logic                wptr_q;
	logic                rptr_q;
	logic [1:0]          count_q;
	logic                do_push;
	logic                do_pop;

	assign q_full     = count_q == 2'd2;
	assign q_rd.valid = count_q != 2'd0;
	assign q_rd.tot   = slot_q[rptr_q];
	assign do_push    = q_wr.push && !q_full;
	assign do_pop     = pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= q_wr.tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full)
		else $error("step totals pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue occupancy out of range");

endmodule

/* hdl/sowc_back.sv */
// sowc_back: bit-serial divider for the field potential and the result register.
// Uses sowc_pkg. Takes step totals from sowc_queue.
module sowc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [8:0]           num_inputs,
	input  sowc_pkg::q_rd_t      q_rd,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output sowc_pkg::result_t    result
);

	sowc_pkg::bk_state_t                 state_q;
	sowc_pkg::bk_state_t                 state_nxt;
	logic [sowc_pkg::NUM_W-1:0]          mag_q;      // dividend, shifts into quotient
	logic [sowc_pkg::DIV_W-1:0]          rem_q;
	logic [sowc_pkg::DIV_W-1:0]          div_q;
	logic                                neg_q;
	logic [sowc_pkg::CNT_W-1:0]          count_q;
	logic [4:0]                          iter_q;
	logic                                out_valid_q;
	sowc_pkg::result_t                   out_q;

	logic signed [sowc_pkg::NUM_W-1:0]   num;
	logic [sowc_pkg::NUM_W-1:0]          num_mag;
	logic [sowc_pkg::DIV_W:0]            rem_sh;
	logic                                qbit;
	logic [sowc_pkg::DIV_W-1:0]          rem_nxt;
	logic signed [sowc_pkg::NUM_W:0]     quo_s;
	logic signed [sowc_pkg::LFP_W-1:0]   lfp_sat;
	logic                                load_out;

	always_comb begin
		num     = sowc_pkg::NUM_W'(q_rd.tot.sum) + sowc_pkg::REST_Q88;
		num_mag = num[sowc_pkg::NUM_W-1] ? sowc_pkg::NUM_W'(-num) : sowc_pkg::NUM_W'(num);
		rem_sh  = {rem_q, mag_q[sowc_pkg::NUM_W-1]};
		qbit    = rem_sh >= {1'b0, div_q};
		rem_nxt = qbit ? sowc_pkg::DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[sowc_pkg::DIV_W-1:0];
		quo_s   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		if (quo_s > sowc_pkg::LFP_MAX) begin
			lfp_sat = sowc_pkg::LFP_MAX[sowc_pkg::LFP_W-1:0];
		end else if (quo_s < sowc_pkg::LFP_MIN) begin
			lfp_sat = sowc_pkg::LFP_MIN[sowc_pkg::LFP_W-1:0];
		end else begin
			lfp_sat = quo_s[sowc_pkg::LFP_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			sowc_pkg::BK_IDLE: begin
				if (q_rd.valid) begin
					pop       = 1'b1;
					state_nxt = sowc_pkg::BK_RUN;
				end
			end
			sowc_pkg::BK_RUN: begin
				if (iter_q == '0) begin
					state_nxt = sowc_pkg::BK_FIN;
				end
			end
			sowc_pkg::BK_FIN: begin
				if (!out_valid_q || result_ready) begin
					load_out  = 1'b1;
					state_nxt = sowc_pkg::BK_IDLE;
				end
			end
			default: state_nxt = sowc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sowc_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q   <= num_mag;
			neg_q   <= num[sowc_pkg::NUM_W-1];
			rem_q   <= '0;
			div_q   <= (num_inputs == '0) ? sowc_pkg::DIV_W'(1) : num_inputs;
			count_q <= q_rd.tot.count;
			iter_q  <= 5'(sowc_pkg::NUM_W - 1);
		end else if (state_q == sowc_pkg::BK_RUN) begin
			mag_q  <= {mag_q[sowc_pkg::NUM_W-2:0], qbit};
			rem_q  <= rem_nxt;
			iter_q <= iter_q - 1'b1;
		end
		if (load_out) begin
			out_q.lfp         <= lfp_sat;
			out_q.spike_count <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == sowc_pkg::BK_FIN))
		else $error("result raised without a finished division");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == sowc_pkg::BK_RUN && iter_q == 5'(sowc_pkg::NUM_W - 1))
		else $error("divider did not start after taking step totals");

endmodule

/* hdl/spike_onset_window_counter.sv */
// spike_onset_window_counter: top level, configuration registers and wiring.
// Uses sowc_pkg, sowc_front, sowc_queue and sowc_back.
//
//  channel   handshake                 payload
//  --------  ------------------------  ----------------------------------
//  sample    sample_valid/sample_ready sample  (channel, voltage, step_last)
//  result    result_valid/result_ready result  (lfp, spike_count)
//  config    cfg_valid/cfg_ready       cfg_index, cfg_data
//
// The front end takes one sample per cycle unless stalled; the onset memory read
//   issued at acceptance is consumed in stage s1.
// Each closed step is divided by a one-bit-per-cycle restoring divider on the
//   27-bit dividend.
// Stalls: the front stalls only on a last sample while the two-entry queue is
//   full; a waiting result keeps the divider from taking the next step until it is read.
// Reset: asynchronous; never-fired flags set, counters clear, registers take defaults, no sweep.
//   cfg_ready is always high.
module spike_onset_window_counter #(
	parameter int MAX_CHANNELS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  sowc_pkg::sample_t   sample,
	output logic                result_valid,
	input  logic                result_ready,
	output sowc_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	sowc_pkg::cfg_t   cfg_q;
	sowc_pkg::q_wr_t  q_wr;
	sowc_pkg::q_rd_t  q_rd;
	logic             q_full;
	logic             pop;

	assign cfg_ready = 1'b1;

	// register file; index three is unmapped and ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= -16'sd7680;
			cfg_q.num_inputs   <= 9'd256;
			cfg_q.window_steps <= 16'd100;
		end else if (cfg_valid) begin
			unique case (sowc_pkg::reg_idx_t'(cfg_index))
				sowc_pkg::REG_THRESHOLD:  cfg_q.threshold    <= cfg_data;
				sowc_pkg::REG_NUM_INPUTS: cfg_q.num_inputs   <= cfg_data[8:0];
				sowc_pkg::REG_WINDOW:     cfg_q.window_steps <= cfg_data;
				default: ;
			endcase
		end
	end

	sowc_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.q_wr         (q_wr),
		.q_full       (q_full)
	);

	sowc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.pop    (pop)
	);

	sowc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_inputs   (cfg_q.num_inputs),
		.q_rd         (q_rd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* test/spike_onset_window_counter_test.sv */
// spike_onset_window_counter_test: self-checking bench for the spike onset window counter.
// Predicts the lfp and spike count of every closed step and checks each result item.
// Depends on sowc_pkg and the spike_onset_window_counter RTL.
module spike_onset_window_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS    = 256;
	localparam int LIMIT       = 400000;  // cycles before the watchdog gives up
	localparam int DRAIN       = 64;      // extra wait so divider and front end are empty
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 60;
	localparam int LONG_STEP   = 1030;    // enough samples to saturate the 26-bit sum

	// Unmapped register index; writes to it must be dropped.
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int    THR_RESET   = -7680;      // -30 mV
	localparam int    REST_OFFSET = -17920;     // -70 mV
	localparam longint SUM_TOP    = 33554431;
	localparam longint SUM_BOTTOM = -33554432;
	localparam longint LFP_TOP    = 65535;
	localparam longint LFP_BOTTOM = -65536;
	localparam int    TALLY_TOP   = 511;

	// Tracks per-channel onset state and the running step totals, and holds the
	// lfp / spike count expected for every step closed but not yet seen.
	class onset_window_scoreboard;
		logic signed [15:0] threshold;
		logic [8:0]         num_inputs;
		logic [15:0]        window_steps;
		logic [31:0]        onset_step [CHANNELS];
		bit                 never_fired [CHANNELS];
		bit                 above [CHANNELS];
		logic [31:0]        step_no;
		longint             volt_sum;
		int                 spike_tally;
		sowc_pkg::result_t  pending [$];
		int                 mismatches;
		int                 results_seen;

		function new();
			threshold = 16'(THR_RESET);
			num_inputs = 9'd256;
			window_steps = 16'd100;
			foreach (never_fired[i]) begin
				never_fired[i] = 1'b1;
				above[i] = 1'b0;
				onset_step[i] = '0;
			end
			step_no = '0;
			volt_sum = 0;
			spike_tally = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (sowc_pkg::reg_idx_t'(idx))
				sowc_pkg::REG_THRESHOLD:  threshold = data;
				sowc_pkg::REG_NUM_INPUTS: num_inputs = data[8:0];
				sowc_pkg::REG_WINDOW:     window_steps = data;
				default: ;
			endcase
		endfunction

		function void note_sample(sowc_pkg::sample_t s);
			int                v;
			int                t;
			int                c;
			bit                in_win;
			logic [31:0]       age;
			longint            divisor;
			longint            quot;
			sowc_pkg::result_t want;
			v = int'(s.voltage);
			t = int'(threshold);
			c = int'(s.channel);
			volt_sum += v;
			if (volt_sum > SUM_TOP) volt_sum = SUM_TOP;
			if (volt_sum < SUM_BOTTOM) volt_sum = SUM_BOTTOM;
			// onset only on the rising crossing
			if (v > t) begin
				if (!above[c]) begin
					onset_step[c] = step_no;
					never_fired[c] = 1'b0;
					above[c] = 1'b1;
				end
			end else begin
				above[c] = 1'b0;
			end
			// never fired: only step zero counts
			age = step_no - onset_step[c];
			in_win = never_fired[c] ? (step_no == 0) : (age <= {16'd0, window_steps});
			if (in_win && spike_tally < TALLY_TOP) spike_tally++;
			if (s.step_last) begin
				divisor = (num_inputs == 0) ? 1 : longint'(num_inputs);
				quot = (volt_sum + REST_OFFSET) / divisor;  // truncates toward zero
				if (quot > LFP_TOP) quot = LFP_TOP;
				if (quot < LFP_BOTTOM) quot = LFP_BOTTOM;
				want.lfp = quot[sowc_pkg::LFP_W-1:0];
				want.spike_count = spike_tally[sowc_pkg::CNT_W-1:0];
				pending = {pending, want};
				volt_sum = 0;
				spike_tally = 0;
				step_no = step_no + 1;
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function void check_result(sowc_pkg::result_t got);
			sowc_pkg::result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				report($sformatf("result %0d arrived with no step pending: lfp %0d count %0d",
					results_seen, got.lfp, got.spike_count));
				return;
			end
			want = pending.pop_front();
			if (got.lfp !== want.lfp)
				report($sformatf("result %0d lfp: expected %0d, got %0d",
					results_seen, want.lfp, got.lfp));
			if (got.spike_count !== want.spike_count)
				report($sformatf("result %0d spike_count: expected %0d, got %0d",
					results_seen, want.spike_count, got.spike_count));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	sowc_pkg::sample_t sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	sowc_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	onset_window_scoreboard sb;
	bit gaps_on = 1'b1;     // sender may drop valid between items
	bit stalls_on = 1'b1;   // receiver may drop ready
	int stall_left = 0;
	int cycle_no = 0;
	int samples_sent = 0;
	int writes_done = 0;

	spike_onset_window_counter uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side backpressure: random bursts of low ready, none when stalls_on is off.
	always @(posedge clk) begin
		if (!stalls_on) begin
			result_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 16);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Every accepted result item is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= LIMIT) begin
			$display("watchdog: %0d cycles, %0d results still pending", cycle_no,
				sb.pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic sowc_pkg::sample_t smp(int ch, int v, bit last);
		sowc_pkg::sample_t s;
		s.channel = 8'(ch);
		s.voltage = 16'(v);
		s.step_last = last;
		return s;
	endfunction

	// Mostly jitter around the threshold so channels cross often; some full-range
	// values and rail values.
	function automatic int pick_voltage(int thr);
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r < 6) v = thr + int'($urandom_range(0, 512)) - 256;
		else if (r < 8) v = int'($urandom_range(0, 65535)) - 32768;
		else if (r == 8) v = 32767;
		else v = -32768;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic send_sample(input sowc_pkg::sample_t s);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		sb.note_sample(s);
		samples_sent++;
	endtask

	// Leaves cfg_valid high; program_regs drops it after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		writes_done++;
	endtask

	task automatic program_regs(input int thr, input logic [15:0] num_word,
			input logic [15:0] win, input bit spare);
		write_reg(sowc_pkg::REG_THRESHOLD, 16'(thr));
		write_reg(sowc_pkg::REG_NUM_INPUTS, num_word);
		write_reg(sowc_pkg::REG_WINDOW, win);
		if (spare) write_reg(REG_SPARE, 16'(int'($urandom_range(0, 65535))));
		cfg_valid <= 1'b0;
	endtask

	// Sender holds off until every closed step has produced its result.
	task automatic wait_results();
		sample_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	// Full quiesce before register writes: results out, divider and front end empty.
	task automatic settle();
		wait_results();
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		int ph;
		int sent;
		int kind;
		int n;
		int k;
		int ch;
		int base;
		int span;
		int thr;
		int r;
		logic [8:0]  num;
		logic [15:0] win;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// ---- directed part, reset register values ----
		// step 0: never-fired channels count; voltage equal to threshold is not above
		send_sample(smp(0, -32768, 1'b0));
		send_sample(smp(255, 32767, 1'b0));
		send_sample(smp(1, THR_RESET, 1'b1));    // negative lfp, truncated toward zero
		// step 1: held-high channel keeps its onset, fresh onset on ch0, ch1 no longer counts
		send_sample(smp(255, 32767, 1'b0));
		send_sample(smp(0, THR_RESET + 1, 1'b0));
		send_sample(smp(1, -32768, 1'b1));
		// alternating bit patterns on channel and voltage
		send_sample(smp(170, 21845, 1'b0));
		send_sample(smp(85, -21846, 1'b1));
		settle();
		// nothing can exceed the top threshold; divisor 1 drives lfp below its floor
		program_regs(32767, 16'd1, 16'd0, 1'b0);
		send_sample(smp(0, -32768, 1'b0));
		send_sample(smp(1, -32768, 1'b1));
		settle();
		// zero divisor is taken as one; lfp above its ceiling; widest window
		program_regs(-32768, 16'd0, 16'hFFFF, 1'b1);
		send_sample(smp(2, 32767, 1'b0));
		send_sample(smp(3, 32767, 1'b0));
		send_sample(smp(4, 32767, 1'b1));
		send_sample(smp(2, -32768, 1'b0));     // drops out of above, rearms ch2
		send_sample(smp(5, -32767, 1'b1));
		send_sample(smp(2, 0, 1'b1));          // second onset on ch2
		settle();
		// zero window: only onsets in the current step count
		program_regs(THR_RESET, 16'd3, 16'd0, 1'b0);
		send_sample(smp(0, 0, 1'b0));
		send_sample(smp(3, 32767, 1'b0));
		send_sample(smp(4, 32767, 1'b1));

		// ---- random part: phases of random register settings ----
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 6) thr = int'($urandom_range(0, 16000)) - 8000;
			else if (r == 6) thr = -32768;
			else if (r == 7) thr = 32767;
			else if (r == 8) thr = int'($urandom_range(0, 65535)) - 32768;
			else thr = THR_RESET;
			if (ph == 2) thr = THR_RESET;  // long positive step must spike on every sample
			r = $urandom_range(0, 9);
			if (r < 5) num = 9'($urandom_range(1, 24));
			else if (r == 5) num = 9'd256;
			else if (r == 6) num = 9'd0;
			else if (r == 7) num = 9'd511;
			else if (r == 8) num = 9'($urandom_range(1, 511));
			else num = 9'd1;
			r = $urandom_range(0, 9);
			if (r < 6) win = 16'($urandom_range(0, 12));
			else if (r == 6) win = 16'd0;
			else if (r == 7) win = 16'hFFFF;
			else if (r == 8) win = 16'($urandom_range(0, 65535));
			else win = 16'($urandom_range(13, 200));
			// upper bits of the num_inputs word are don't-care
			program_regs(thr, {7'($urandom_range(0, 127)), num}, win, ph == 4);

			// last phase runs with no idling on either side
			gaps_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stalls_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);

			// channels in use this phase: a contiguous block that may wrap past 255
			base = $urandom_range(0, 255);
			span = (ph % 3 == 0) ? $urandom_range(1, 4) : $urandom_range(2, 24);

			// one huge step on the top rail: sum and count saturate, lfp clamps
			if (ph == 2)
				for (k = 0; k < LONG_STEP; k++)
					send_sample(smp($urandom_range(0, 255), 32767, k == LONG_STEP - 1));

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(0, 19);
				if (kind < 17) begin
					// a step over the phase's channels in order, sometimes cut short;
					// kind 16 scrambles the order and repeats channels
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
					for (k = 0; k < n; k++) begin
						ch = (kind == 16 && $urandom_range(0, 2) == 0) ?
							$urandom_range(0, span - 1) : k;
						send_sample(smp(base + ch, pick_voltage(thr), k == n - 1));
					end
				end else begin
					// noise: any channel, any voltage, step marks at random
					n = $urandom_range(1, 10);
					for (k = 0; k < n; k++)
						send_sample(smp($urandom_range(0, 255),
							int'($urandom_range(0, 65535)) - 32768,
							k == n - 1 || $urandom_range(0, 3) == 0));
				end
				sent += n;
				if (ph != PHASES - 1 && $urandom_range(0, 24) == 0) wait_results();
			end
		end

		wait_results();
		repeat (DRAIN) @(posedge clk);
		$display("%0d samples, %0d step results checked, %0d register writes, %0d phases",
			samples_sent, sb.results_seen, writes_done, PHASES + 4);
		$display("covered rail voltages, lfp and count saturation, window 0 and 65535");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/sowc_pkg.sv
hdl/sowc_front.sv
hdl/sowc_queue.sv
hdl/sowc_back.sv
hdl/spike_onset_window_counter.sv
test/spike_onset_window_counter_test.sv
